>>> rtl/sme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute package
// Shared opcodes, status codes, kinds, sizes and controller/datapath types.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int HEAP_WORDS_DEF  = 1024;

  typedef enum logic [4:0] {
    OP_PUSH     = 5'd0,
    OP_DUP      = 5'd1,
    OP_COPY     = 5'd2,
    OP_SWAP     = 5'd3,
    OP_DISCARD  = 5'd4,
    OP_SLIDE    = 5'd5,
    OP_ADD      = 5'd6,
    OP_SUB      = 5'd7,
    OP_MUL      = 5'd8,
    OP_DIV      = 5'd9,
    OP_MOD      = 5'd10,
    OP_STORE    = 5'd11,
    OP_RETRIEVE = 5'd12,
    OP_OUTCHAR  = 5'd13,
    OP_OUTNUM   = 5'd14,
    OP_INCHAR   = 5'd15,
    OP_INNUM    = 5'd16
  } opcode_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_BADADDR   = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_NUM  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch request fields
    logic rd_top;    // read stack at count-1
    logic rd_next;   // read stack at count-2
    logic rd_copy;   // read stack at count-operand
    logic rd_heap;   // read heap at popped address
    logic div_start;
    logic wr_a;      // write stage A result
    logic wr_b;      // write stage B result
    logic wr_heap;
    logic commit;    // update count and present result
  } sme_cmd_t;

  typedef struct packed {
    logic div_done;
  } sme_sts_t;

endpackage

>>> rtl/stack_machine_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute
// Executes one stack-machine instruction per request, one result each.
//
//   channel | ports                                        | direction
//   in      | in_valid in_stall opcode operand value       | request in
//   out     | out_valid out_stall status kind value depth  | result out
//
// A request passes through accept, the reads READ and READ2, and execute,
// and its result is valid in the cycle after execute, when the next request
// may be accepted. Swap adds the second write state SWAP2, and div and mod
// wait in S_DIV for the one-bit-a-cycle divider. After reset the heap is
// cleared, one word a cycle, before the first request is taken. A result
// waits in its output register while the next request is accepted and read;
// that request holds in execute until the waiting result is taken.
// ----------------------------------------------------------------------------
module stack_machine_execute #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int HEAP_WORDS  = sme_pkg::HEAP_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_opcode,
  input  logic [31:0] in_operand,
  input  logic [31:0] in_in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_out_kind,
  output logic [31:0] out_out_value,
  output logic [8:0]  out_depth_now
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int HW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;

  sme_pkg::sme_cmd_t cmd;
  sme_pkg::sme_sts_t sts;
  logic clr_en;
  logic [HW-1:0] clr_addr;
  logic [CW-1:0] depth;

  sme_control #(.HEAP_WORDS(HEAP_WORDS)) u_ctl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts), .clr_en(clr_en), .clr_addr(clr_addr)
  );

  sme_datapath #(.STACK_DEPTH(STACK_DEPTH), .HEAP_WORDS(HEAP_WORDS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_opcode(in_opcode), .in_operand(in_operand), .in_in_value(in_in_value),
    .clr_en(clr_en), .clr_addr(clr_addr),
    .res_status(out_status), .res_kind(out_out_kind), .res_value(out_out_value),
    .res_depth(depth)
  );

  assign out_depth_now = 9'(depth);

endmodule

>>> rtl/sme_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine divider
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sme_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [31:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    shifted = {rem_r[31:0], q_r[31]};
    diff = shifted - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend[31] ? (32'd0 - dividend) : dividend;
      d_nxt = divisor[31] ? (32'd0 - divisor) : divisor;
      rem_nxt = 33'd0;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
      qneg_nxt = dividend[31] ^ divisor[31];
      rneg_nxt = dividend[31];
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff;
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign done = done_r;
  assign quotient = qneg_r ? (32'd0 - q_r) : q_r;
  assign remainder = rneg_r ? (32'd0 - rem_r[31:0]) : rem_r[31:0];

endmodule

>>> rtl/sme_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine datapath
// Stack and heap memories, stack count, checks, ALU and result registers.
// ----------------------------------------------------------------------------
module sme_datapath #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int HEAP_WORDS  = sme_pkg::HEAP_WORDS_DEF,
  parameter int CW = $clog2(STACK_DEPTH + 1),
  parameter int SW = $clog2(STACK_DEPTH),
  parameter int HW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sme_pkg::sme_cmd_t cmd,
  output sme_pkg::sme_sts_t sts,
  input  logic [4:0]        in_opcode,
  input  logic [31:0]       in_operand,
  input  logic [31:0]       in_in_value,
  input  logic              clr_en,
  input  logic [HW-1:0]     clr_addr,
  output logic [2:0]        res_status,
  output logic [1:0]        res_kind,
  output logic [31:0]       res_value,
  output logic [CW-1:0]     res_depth
);

  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] heap_mem  [HEAP_WORDS];

  logic [4:0]    op_r;
  logic [31:0]   opd_r, inv_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   top_r, nxt_r, cpy_r, heap_r;
  logic          cpy_ok_r, addr_ok_r;
  logic [31:0]   div_q, div_rem;
  logic          div_done;

  logic [2:0]    st_c;
  logic [CW-1:0] cnt_c;
  logic [31:0]   val_c;
  logic [1:0]    kind_c;
  logic [CW-1:0] wa_c, wb_c;
  logic [31:0]   da_c, db_c;
  logic [31:0]   prod_c;
  logic [32:0]   cnt_ext, opd_lim;
  logic          cpy_ok_c;
  logic [CW-1:0] cpy_idx;
  logic [31:0]   haddr_c;

  assign sts.div_done = div_done;

  sme_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(nxt_r), .divisor(top_r),
    .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  assign cnt_ext = {{(33-CW){1'b0}}, cnt_r};
  assign opd_lim = {opd_r[31], opd_r};
  assign cpy_ok_c = !opd_r[31] && (opd_r != 32'd0) && ($signed(opd_lim) <= $signed(cnt_ext));
  assign cpy_idx = cnt_r - opd_r[CW-1:0];
  assign haddr_c = (op_r == sme_pkg::OP_RETRIEVE || op_r == sme_pkg::OP_INCHAR ||
                    op_r == sme_pkg::OP_INNUM) ? top_r : nxt_r;
  assign prod_c = nxt_r * top_r;

  always_comb begin
    st_c = sme_pkg::ST_OK;
    cnt_c = cnt_r;
    val_c = 32'd0;
    kind_c = sme_pkg::KIND_NONE;
    wa_c = cnt_r - CW'(1);
    wb_c = cnt_r - CW'(2);
    da_c = 32'd0;
    db_c = top_r;
    case (op_r)
      sme_pkg::OP_PUSH: begin
        if (cnt_r >= CW'(STACK_DEPTH)) st_c = sme_pkg::ST_OVERFLOW;
        else begin wa_c = cnt_r; da_c = opd_r; cnt_c = cnt_r + CW'(1); end
      end
      sme_pkg::OP_DUP: begin
        if (cnt_r < CW'(1)) st_c = sme_pkg::ST_UNDERFLOW;
        else if (cnt_r >= CW'(STACK_DEPTH)) st_c = sme_pkg::ST_OVERFLOW;
        else begin wa_c = cnt_r; da_c = top_r; cnt_c = cnt_r + CW'(1); end
      end
      sme_pkg::OP_COPY: begin
        if (cnt_r >= CW'(STACK_DEPTH)) st_c = sme_pkg::ST_OVERFLOW;
        else begin
          wa_c = cnt_r; da_c = cpy_ok_r ? cpy_r : 32'd0; cnt_c = cnt_r + CW'(1);
        end
      end
      sme_pkg::OP_SWAP: begin
        if (cnt_r < CW'(2)) st_c = sme_pkg::ST_UNDERFLOW;
        else begin da_c = nxt_r; db_c = top_r; end
      end
      sme_pkg::OP_DISCARD: begin
        if (cnt_r < CW'(1)) st_c = sme_pkg::ST_UNDERFLOW;
        else cnt_c = cnt_r - CW'(1);
      end
      sme_pkg::OP_SLIDE: begin
        if (cnt_r < CW'(1)) st_c = sme_pkg::ST_UNDERFLOW;
        else if (!opd_r[31] && opd_r != 32'd0) begin
          if ($signed(opd_lim) > $signed(cnt_ext - 33'd1)) st_c = sme_pkg::ST_UNDERFLOW;
          else begin
            cnt_c = cnt_r - opd_r[CW-1:0];
            wa_c = cnt_c - CW'(1);
            da_c = top_r;
          end
        end
      end
      sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
      sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
        if (cnt_r < CW'(2)) st_c = sme_pkg::ST_UNDERFLOW;
        else if ((op_r == sme_pkg::OP_DIV || op_r == sme_pkg::OP_MOD) && top_r == 32'd0)
          st_c = sme_pkg::ST_DIVZERO;
        else begin
          wa_c = cnt_r - CW'(2);
          cnt_c = cnt_r - CW'(1);
          case (op_r)
            sme_pkg::OP_ADD: da_c = nxt_r + top_r;
            sme_pkg::OP_SUB: da_c = nxt_r - top_r;
            sme_pkg::OP_MUL: da_c = prod_c;
            sme_pkg::OP_DIV: da_c = div_q;
            default:         da_c = div_rem;
          endcase
        end
      end
      sme_pkg::OP_STORE: begin
        if (cnt_r < CW'(2)) st_c = sme_pkg::ST_UNDERFLOW;
        else if (!addr_ok_r) st_c = sme_pkg::ST_BADADDR;
        else cnt_c = cnt_r - CW'(2);
      end
      sme_pkg::OP_RETRIEVE: begin
        if (cnt_r < CW'(1)) st_c = sme_pkg::ST_UNDERFLOW;
        else da_c = addr_ok_r ? heap_r : 32'd0;
      end
      sme_pkg::OP_OUTCHAR, sme_pkg::OP_OUTNUM: begin
        if (cnt_r < CW'(1)) st_c = sme_pkg::ST_UNDERFLOW;
        else begin
          cnt_c = cnt_r - CW'(1);
          if (op_r == sme_pkg::OP_OUTCHAR) begin
            kind_c = sme_pkg::KIND_CHAR; val_c = {24'd0, top_r[7:0]};
          end else begin
            kind_c = sme_pkg::KIND_NUM; val_c = top_r;
          end
        end
      end
      sme_pkg::OP_INCHAR, sme_pkg::OP_INNUM: begin
        if (cnt_r < CW'(1)) st_c = sme_pkg::ST_UNDERFLOW;
        else if (!addr_ok_r) st_c = sme_pkg::ST_BADADDR;
        else cnt_c = cnt_r - CW'(1);
      end
      default: ;
    endcase
  end

  logic wr_a_en, wr_b_en, wr_h_en;
  logic [31:0] heap_wdata;
  assign wr_a_en = cmd.wr_a && (st_c == sme_pkg::ST_OK) &&
                   (op_r <= sme_pkg::OP_RETRIEVE) && (op_r != sme_pkg::OP_DISCARD) &&
                   (op_r != sme_pkg::OP_STORE) &&
                   !(op_r == sme_pkg::OP_SLIDE && cnt_c == cnt_r);
  assign wr_b_en = cmd.wr_b && (st_c == sme_pkg::ST_OK) && (op_r == sme_pkg::OP_SWAP);
  assign wr_h_en = cmd.wr_heap && (st_c == sme_pkg::ST_OK) &&
                   (op_r == sme_pkg::OP_STORE || op_r == sme_pkg::OP_INCHAR ||
                    op_r == sme_pkg::OP_INNUM);
  assign heap_wdata = (op_r == sme_pkg::OP_STORE) ? top_r :
                      (op_r == sme_pkg::OP_INCHAR) ? {24'd0, inv_r[7:0]} : inv_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_opcode;
      opd_r <= in_operand;
      inv_r <= in_in_value;
    end
    if (cmd.rd_top) top_r <= stack_mem[SW'(cnt_r - CW'(1))];
    if (cmd.rd_next) nxt_r <= stack_mem[SW'(cnt_r - CW'(2))];
    if (cmd.rd_copy) begin
      cpy_r <= stack_mem[SW'(cpy_idx)];
      cpy_ok_r <= cpy_ok_c;
    end
    if (cmd.rd_heap) begin
      heap_r <= heap_mem[HW'(haddr_c)];
      addr_ok_r <= haddr_c < 32'(HEAP_WORDS);
    end
    if (wr_a_en) stack_mem[SW'(wa_c)] <= da_c;
    else if (wr_b_en) stack_mem[SW'(wb_c)] <= db_c;
    if (clr_en) heap_mem[clr_addr] <= 32'd0;
    else if (wr_h_en) heap_mem[HW'(haddr_c)] <= heap_wdata;
    if (cmd.commit) begin
      res_status <= st_c;
      res_kind <= kind_c;
      res_value <= val_c;
      res_depth <= cnt_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.commit) cnt_r <= cnt_c;
  end

endmodule

>>> rtl/sme_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine controller
// Sequences heap clear, request capture, reads, execution and delivery.
// ----------------------------------------------------------------------------
module sme_control #(
  parameter int HEAP_WORDS = sme_pkg::HEAP_WORDS_DEF,
  parameter int HW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [4:0]        in_opcode,
  output logic              out_valid,
  input  logic              out_stall,
  output sme_pkg::sme_cmd_t cmd,
  input  sme_pkg::sme_sts_t sts,
  output logic              clr_en,
  output logic [HW-1:0]     clr_addr
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_READ2, S_DIV, S_EXEC, S_SWAP2
  } state_t;

  state_t state_r, state_nxt;
  logic [HW-1:0] clr_r, clr_nxt;
  logic [4:0] op_r, op_nxt;
  logic ov_r, ov_nxt;
  logic in_acc, op_div, res_free;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign clr_en = (state_r == S_CLEAR);
  assign clr_addr = clr_r;
  assign op_div = (op_r == sme_pkg::OP_DIV) || (op_r == sme_pkg::OP_MOD);
  assign res_free = !ov_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    op_nxt = op_r;
    ov_nxt = ov_r && out_stall;
    cmd = '0;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + HW'(1);
        if (clr_r == HW'(HEAP_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd.capture = 1'b1;
          op_nxt = in_opcode;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_top = 1'b1;
        cmd.rd_next = 1'b1;
        state_nxt = S_READ2;
      end
      S_READ2: begin
        cmd.rd_copy = 1'b1;
        cmd.rd_heap = 1'b1;
        if (op_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else state_nxt = S_EXEC;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (res_free) begin
          cmd.wr_a = 1'b1;
          cmd.wr_heap = 1'b1;
          if (op_r == sme_pkg::OP_SWAP) state_nxt = S_SWAP2;
          else begin
            cmd.commit = 1'b1;
            ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SWAP2: begin
        cmd.wr_b = 1'b1;
        cmd.commit = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      ov_r <= 1'b0;
      op_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
      op_r <= op_nxt;
    end
  end

endmodule
